@@ hdl/uhgp_pkg.sv @@
// ----------------------------------------------------------------------------
// uhgp_pkg
// Shared types, codes and constants for the UTF-8 / Hangul glyph placer.
// ----------------------------------------------------------------------------
package uhgp_pkg;

    // Input opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_UTF8 = 2'd1;
    localparam logic [1:0] OP_UCS2 = 2'd2;

    // Configuration register indexes
    localparam logic CFG_WRAP_COLUMN = 1'b0;
    localparam logic CFG_LINE_HEIGHT = 1'b1;

    localparam logic [5:0] WRAP_COLUMN_RST = 6'd38;
    localparam logic [5:0] LINE_HEIGHT_RST = 6'd12;

    // Command queue depth (power of two)
    localparam int QUEUE_DEPTH_DEF = 4;

    // Character codes
    localparam logic [15:0] HANGUL_FIRST  = 16'hAC00;
    localparam logic [15:0] HANGUL_LAST   = 16'hD7A3;
    localparam logic [15:0] PRINT_FIRST   = 16'h0020;
    localparam logic [15:0] FALLBACK_CODE = 16'h007F;

    // Glyph bases
    localparam logic [6:0] MEDIAL_BASE = 7'd57;
    localparam logic [6:0] FINAL_BASE  = 7'd78;
    localparam logic [6:0] CHO_COUNT   = 7'd19;

    // Reciprocals for the syllable split (exact for index < 11172)
    localparam logic [14:0] RECIP_588   = 15'd28533;  // shift 24
    localparam logic [13:0] RECIP_28    = 14'd9363;   // shift 18
    localparam logic [8:0]  JUNG_COUNT  = 9'd21;
    localparam logic [13:0] JONG_COUNT  = 14'd28;

    // Framebuffer
    localparam logic [15:0] HIRES_BASE  = 16'h2000;
    localparam logic [7:0]  ROW_LIMIT   = 8'd192;

    // One command from the front to the back
    typedef struct packed {
        logic        is_load;
        logic [15:0] code;
        logic [5:0]  x;
        logic [7:0]  y;
    } t_cmd;

    function automatic logic is_hangul(input logic [15:0] code);
        is_hangul = (code >= HANGUL_FIRST) && (code <= HANGUL_LAST);
    endfunction

    // Vowel shape class: 0 vertical, 1 horizontal, 2 mixed
    function automatic logic [1:0] vowel_shape(input logic [4:0] jung);
        case (jung)
            5'd8, 5'd12, 5'd13, 5'd17, 5'd18:                vowel_shape = 2'd1;
            5'd9, 5'd10, 5'd11, 5'd14, 5'd15, 5'd16, 5'd19:  vowel_shape = 2'd2;
            default:                                         vowel_shape = 2'd0;
        endcase
    endfunction

endpackage

@@ hdl/utf8_hangul_glyph_placer.sv @@
// A word passes the command queue, back stages A and B and the output register.
// Throughput: one word per cycle on both sides while the queue has room and the
// output is taken; a back stage holds only when it is full and the next one holds.
// Reset: synchronous, active low; clears cursor, UTF-8 state, queue and
// pipeline, and loads wrap column 38 and line height 12.
// ----------------------------------------------------------------------------
// utf8_hangul_glyph_placer
// UTF-8 / UCS-2 text placer: glyph indices, cursor and hi-res row address.
// ----------------------------------------------------------------------------
module utf8_hangul_glyph_placer import uhgp_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // value[15:0], load_x[21:16], load_y[29:22], zero[31:30]
    input  logic [31:0] i_s_tdata,
    // opcode[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // ascii_glyph[6:0], initial_glyph[13:7], medial_glyph[20:14],
    // final_glyph[27:21], screen_x[33:28], screen_y[41:34],
    // top_address[57:42], offscreen[58], zero[63:59]
    output logic [63:0] o_m_tdata,
    // glyph_kind[0]
    output logic        o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data
);

    logic       push, pop, q_empty, q_full;
    t_cmd       cmd_in, cmd_out;
    logic [6:0] ascii_g, initial_g, medial_g, final_g;
    logic [5:0] scr_x;
    logic [7:0] scr_y;
    logic [15:0] top_addr;
    logic       offscr;

    assign o_cfg_ready = 1'b1;

    uhgp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_opcode (i_s_tuser),
        .i_value  (i_s_tdata[15:0]),
        .i_load_x (i_s_tdata[21:16]),
        .i_load_y (i_s_tdata[29:22]),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    uhgp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    uhgp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (!q_empty),
        .i_cmd           (cmd_out),
        .o_pop           (pop),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_m_tvalid),
        .i_ready         (i_m_tready),
        .o_glyph_kind    (o_m_tuser),
        .o_ascii_glyph   (ascii_g),
        .o_initial_glyph (initial_g),
        .o_medial_glyph  (medial_g),
        .o_final_glyph   (final_g),
        .o_screen_x      (scr_x),
        .o_screen_y      (scr_y),
        .o_top_address   (top_addr),
        .o_offscreen     (offscr)
    );

    // Output word packing
    assign o_m_tdata = {5'd0, offscr, top_addr, scr_y, scr_x,
                        final_g, medial_g, initial_g, ascii_g};

endmodule

@@ hdl/uhgp_front.sv @@
// ----------------------------------------------------------------------------
// uhgp_front
// Accepts input words, assembles UTF-8 sequences and issues cursor loads and
// printable codes as commands to the queue.
// ----------------------------------------------------------------------------
module uhgp_front import uhgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_value,
    input  logic [5:0]  i_load_x,
    input  logic [7:0]  i_load_y,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [1:0]  r_pend, n_pend;
    logic [15:0] r_part, n_part;
    logic        r_long, n_long;
    logic        acc, emit, load;
    logic [15:0] code;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;

    // UTF-8 assembly
    always_comb begin
        n_pend = r_pend;
        n_part = r_part;
        n_long = r_long;
        emit   = 1'b0;
        load   = 1'b0;
        code   = i_value;
        if (acc) begin
            case (i_opcode)
                OP_LOAD: begin
                    load = 1'b1;
                end
                OP_UCS2: begin
                    emit = 1'b1;
                end
                OP_UTF8: begin
                    if (r_pend != 2'd0) begin
                        // continuation: taken as such whatever its value
                        n_part = {r_part[9:0], i_value[5:0]};
                        n_pend = r_pend - 2'd1;
                        if (r_pend == 2'd1) begin
                            emit   = 1'b1;
                            n_long = 1'b0;
                            code   = r_long ? FALLBACK_CODE : n_part;
                        end
                    end else if (!i_value[7]) begin
                        emit = 1'b1;
                        code = {8'd0, i_value[7:0]};
                    end else if (i_value[7:6] == 2'b10) begin
                        emit = 1'b1;
                        code = FALLBACK_CODE;
                    end else if (i_value[7:5] == 3'b110) begin
                        n_part = {11'd0, i_value[4:0]};
                        n_pend = 2'd1;
                    end else if (i_value[7:4] == 4'b1110) begin
                        n_part = {12'd0, i_value[3:0]};
                        n_pend = 2'd2;
                    end else if (i_value[7:3] == 5'b11110) begin
                        n_part = 16'd0;
                        n_pend = 2'd3;
                        n_long = 1'b1;
                    end else begin
                        emit = 1'b1;
                        code = FALLBACK_CODE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Command out: control codes are dropped, unsupported codes fall back
    always_comb begin
        o_push        = load || (emit && (code >= PRINT_FIRST));
        o_cmd.is_load = load;
        o_cmd.x       = i_load_x;
        o_cmd.y       = i_load_y;
        if (is_hangul(code) || (code < 16'h0080)) begin
            o_cmd.code = code;
        end else begin
            o_cmd.code = FALLBACK_CODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_part <= 16'd0;
            r_long <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_part <= n_part;
            r_long <= n_long;
        end
    end

endmodule

@@ hdl/uhgp_queue.sv @@
// ----------------------------------------------------------------------------
// uhgp_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module uhgp_queue import uhgp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ hdl/uhgp_back.sv @@
// ----------------------------------------------------------------------------
// uhgp_back
// Places commands: cursor, address and advance in the first stage, syllable
// split by reciprocal multiply in the second, glyph indices into the output
// register in the third.
// ----------------------------------------------------------------------------
module uhgp_back import uhgp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_glyph_kind,
    output logic [6:0]  o_ascii_glyph,
    output logic [6:0]  o_initial_glyph,
    output logic [6:0]  o_medial_glyph,
    output logic [6:0]  o_final_glyph,
    output logic [5:0]  o_screen_x,
    output logic [7:0]  o_screen_y,
    output logic [15:0] o_top_address,
    output logic        o_offscreen
);

    logic [5:0]  r_wrap_col, r_line_h;
    logic [5:0]  r_cur_col, n_cur_col;
    logic [7:0]  r_cur_row, n_cur_row;

    logic        en_a, en_b, en_o, take;
    logic        hangul;
    logic [6:0]  col_sum;
    logic [15:0] addr;

    // stage A
    logic        r_a_v, r_a_hangul, r_a_off;
    logic [13:0] r_a_idx;
    logic [6:0]  r_a_ascii;
    logic [5:0]  r_a_x;
    logic [7:0]  r_a_y;
    logic [15:0] r_a_addr;
    // stage B
    logic        r_b_v, r_b_hangul, r_b_off;
    logic [13:0] r_b_idx;
    logic [6:0]  r_b_ascii;
    logic [5:0]  r_b_x;
    logic [7:0]  r_b_y;
    logic [15:0] r_b_addr;
    logic [4:0]  r_b_cho;
    logic [8:0]  r_b_q28;
    // output
    logic        r_o_v;

    logic [28:0] p_cho;
    logic [27:0] p_q28;
    logic [8:0]  jung_w;
    logic [13:0] jong_w;
    logic [4:0]  jung, jong;
    logic [1:0]  shape;

    // Stall chain: a stage moves when it is empty or the next one moves
    assign en_o  = !r_o_v || i_ready;
    assign en_b  = !r_b_v || en_o;
    assign en_a  = !r_a_v || en_b;
    assign take  = i_cmd_valid && en_a;
    assign o_pop = take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_col <= WRAP_COLUMN_RST;
            r_line_h   <= LINE_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WRAP_COLUMN: r_wrap_col <= i_cfg_data;
                CFG_LINE_HEIGHT: r_line_h   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage A: classify, row address, cursor advance
    assign hangul  = is_hangul(i_cmd.code);
    assign col_sum = {1'b0, r_cur_col} + (hangul ? 7'd2 : 7'd1);
    assign addr    = HIRES_BASE
                   + {3'd0, r_cur_row[2:0], 10'd0}
                   + {6'd0, r_cur_row[5:3], 7'd0}
                   + {9'd0, r_cur_row[7:6], 5'd0}
                   + {11'd0, r_cur_row[7:6], 3'd0}
                   + {10'd0, r_cur_col};

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (take) begin
            if (i_cmd.is_load) begin
                n_cur_col = i_cmd.x;
                n_cur_row = i_cmd.y;
            end else if (col_sum > {1'b0, r_wrap_col}) begin
                n_cur_col = 6'd0;
                n_cur_row = r_cur_row + {2'd0, r_line_h};
            end else begin
                n_cur_col = col_sum[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= 6'd0;
            r_cur_row <= 8'd0;
        end else begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en_a) begin
            r_a_v <= take && !i_cmd.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_hangul <= hangul;
            r_a_idx    <= 14'(i_cmd.code - HANGUL_FIRST);
            r_a_ascii  <= i_cmd.code[6:0] - PRINT_FIRST[6:0];
            r_a_x      <= r_cur_col;
            r_a_y      <= r_cur_row;
            r_a_off    <= (r_cur_row >= ROW_LIMIT);
            r_a_addr   <= (r_cur_row >= ROW_LIMIT) ? 16'd0 : addr;
        end
    end

    // Stage B: initial index and index / 28 by reciprocal multiply
    assign p_cho = 29'(r_a_idx) * 29'(RECIP_588);
    assign p_q28 = 28'(r_a_idx) * 28'(RECIP_28);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_hangul <= r_a_hangul;
            r_b_idx    <= r_a_idx;
            r_b_ascii  <= r_a_ascii;
            r_b_x      <= r_a_x;
            r_b_y      <= r_a_y;
            r_b_off    <= r_a_off;
            r_b_addr   <= r_a_addr;
            r_b_cho    <= p_cho[28:24];
            r_b_q28    <= p_q28[26:18];
        end
    end

    // Stage C: vowel and final indices, glyph numbers
    assign jung_w = r_b_q28 - 9'(r_b_cho) * JUNG_COUNT;
    assign jong_w = r_b_idx - 14'(r_b_q28) * JONG_COUNT;
    assign jung   = jung_w[4:0];
    assign jong   = jong_w[4:0];
    assign shape  = vowel_shape(jung);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en_o) begin
            r_o_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            o_glyph_kind    <= r_b_hangul;
            o_ascii_glyph   <= r_b_hangul ? 7'd0 : r_b_ascii;
            o_initial_glyph <= r_b_hangul ? 7'(shape) * CHO_COUNT + 7'(r_b_cho) : 7'd0;
            o_medial_glyph  <= r_b_hangul ? MEDIAL_BASE + 7'(jung) : 7'd0;
            o_final_glyph   <= r_b_hangul ? FINAL_BASE + 7'(jong) : 7'd0;
            o_screen_x      <= r_b_x;
            o_screen_y      <= r_b_y;
            o_top_address   <= r_b_addr;
            o_offscreen     <= r_b_off;
        end
    end

    assign o_valid = r_o_v;

endmodule

@@ hdl/uhgp_checker.sv @@
// ----------------------------------------------------------------------------
// uhgp_checker
// Port-level checks on the glyph placer's result stream.
// ----------------------------------------------------------------------------
module uhgp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tuser
);

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // Offscreen flag follows the row and zeroes the address
    a_offscreen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[58] == (o_m_tdata[41:34] >= 8'd192))
                       && (!o_m_tdata[58] || (o_m_tdata[57:42] == 16'd0)))
        else $error("offscreen flag or address inconsistent");

    // ASCII words carry no jamo, Hangul words no ASCII glyph
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser ? (o_m_tdata[6:0] == 7'd0 && o_m_tdata[20:14] >= 7'd57
                                     && o_m_tdata[27:21] >= 7'd78)
                                  : (o_m_tdata[27:7] == 21'd0)))
        else $error("glyph fields do not match glyph kind");

    // Padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[63:59] == 5'd0)
        else $error("padding bits set in result word");

endmodule

bind utf8_hangul_glyph_placer uhgp_checker u_chk (.*);
